@@ hdl/trie_insert_prefix_count_macros.svh @@
// Assertion macros shared by the trie prefix-count checker.
// Needs nothing else; take it in with an include of the bare file name.
`ifndef TRIE_INSERT_PREFIX_COUNT_MACROS_SVH
`define TRIE_INSERT_PREFIX_COUNT_MACROS_SVH

// Same-cycle implication, off while reset is low.
`define TIPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is low.
`define TIPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also runs through reset.
`define TIPC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/tipc_pkg.sv @@
// Shared types and constants for the trie prefix-count block.
// No dependencies; used by the top level and the checker.
`timescale 1ns / 1ps

package tipc_pkg;

  localparam int LETTER_W = 5;
  localparam int SUM_W    = 24;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_POOL_FULL = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [LETTER_W-1:0] letter;
    logic                last;
  } tipc_in_t;

  typedef struct packed {
    logic             done_kind;
    logic [SUM_W-1:0] prefix_words;
    logic             status;
  } tipc_out_t;

endpackage

@@ hdl/trie_insert_prefix_count.sv @@
// Trie prefix-count block: top level with the per-letter sequencer.
// Depends on tipc_pkg and tipc_ram.
//
// Usage:
//   Input channel in_valid/in_stall/in_data moves one letter per transfer:
//   kind (0 insert, 1 query), letter (0..ALPHABET-1, larger is clamped) and
//   last. Output channel out_valid/out_stall/out_data gives one result per
//   word, on its last letter: done_kind, prefix_words (queries only) and
//   status (1 when the node pool ran out).
//   Sequencing: one letter at a time. A letter on an intact path goes through
//   the child lookup in the child memory, then for a query the word-count
//   read and sum. A last letter also loads the output register, after the
//   count update on insert. Letters after a broken path skip the lookup and
//   go straight to the output register when last.
//   Reset: all control state clears, then a clearing pass writes zero to
//   every child entry, one a cycle, clearing the word counts alongside.
//   in_stall stays high throughout.
//   Stall: the result waits in the output register; later letters of the
//   next word are still taken until a new result needs the register.
`timescale 1ns / 1ps

module trie_insert_prefix_count #(
  parameter int NODE_COUNT      = 4096,
  parameter int ALPHABET        = 26,
  parameter int WORD_COUNT_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tipc_pkg::tipc_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tipc_pkg::tipc_out_t out_data
);

  import tipc_pkg::*;

  localparam int NODE_W = $clog2(NODE_COUNT);
  localparam int USED_W = $clog2(NODE_COUNT + 1);
  localparam int SLOTS  = NODE_COUNT * ALPHABET;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int ADD_W  = ((WORD_COUNT_BITS > SUM_W) ? WORD_COUNT_BITS : SUM_W) + 1;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);
  localparam logic [SLOT_W-1:0] ALPHA_K   = SLOT_W'(ALPHABET);
  localparam logic [USED_W-1:0] USED_MAX  = USED_W'(NODE_COUNT);
  localparam logic [SLOT_W-1:0] CNT_LIMIT = SLOT_W'(NODE_COUNT);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_LOOK  = 3'd2;
  localparam logic [2:0] ST_ADD   = 3'd3;
  localparam logic [2:0] ST_INC   = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  // Control state
  logic [2:0]        state_r,    state_nxt;
  logic [SLOT_W-1:0] clr_addr_r, clr_addr_nxt;
  logic [NODE_W-1:0] cursor_r,   cursor_nxt;
  logic [SUM_W-1:0]  sum_r,      sum_nxt;
  logic              broken_r,   broken_nxt;
  logic              ovf_r,      ovf_nxt;
  logic [USED_W-1:0] used_r,     used_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Payload state
  logic              kind_r,     kind_nxt;
  logic              last_r,     last_nxt;
  logic [SLOT_W-1:0] slot_r,     slot_nxt;
  logic [NODE_W-1:0] end_node_r, end_node_nxt;
  tipc_out_t         out_data_r, out_data_nxt;

  // Memory ports
  logic                       child_we;
  logic [SLOT_W-1:0]          child_waddr;
  logic [NODE_W-1:0]          child_wdata;
  logic [SLOT_W-1:0]          child_raddr;
  logic [NODE_W-1:0]          child_rdata;
  logic                       cnt_we;
  logic [NODE_W-1:0]          cnt_waddr;
  logic [WORD_COUNT_BITS-1:0] cnt_wdata;
  logic [NODE_W-1:0]          cnt_raddr;
  logic [WORD_COUNT_BITS-1:0] cnt_rdata;

  logic [LETTER_W-1:0]        letter_c;
  logic [SLOT_W-1:0]          slot_in;
  logic                       in_xfer;
  logic                       out_free;
  logic                       alloc;
  logic [NODE_W-1:0]          look_node;
  logic [ADD_W-1:0]           sum_ext;
  logic [WORD_COUNT_BITS-1:0] cnt_inc;

  tipc_ram #(.DEPTH(SLOTS), .WIDTH(NODE_W)) u_child (
    .clk   (clk),
    .we    (child_we),
    .waddr (child_waddr),
    .wdata (child_wdata),
    .raddr (child_raddr),
    .rdata (child_rdata)
  );

  tipc_ram #(.DEPTH(NODE_COUNT), .WIDTH(WORD_COUNT_BITS)) u_count (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    if (32'(in_data.letter) >= ALPHABET) begin
      letter_c = LETTER_W'(ALPHABET - 1);
    end else begin
      letter_c = in_data.letter;
    end
  end

  assign slot_in     = SLOT_W'(cursor_r) * ALPHA_K + SLOT_W'(letter_c);
  assign child_raddr = slot_in;

  // Missing insert child with room left: take the next free node
  assign alloc     = (kind_r == KIND_INSERT) && (child_rdata == '0) && (used_r < USED_MAX);
  assign look_node = alloc ? used_r[NODE_W-1:0] : child_rdata;
  assign cnt_raddr = look_node;

  assign sum_ext = ADD_W'(sum_r) + ADD_W'(cnt_rdata);
  assign cnt_inc = (cnt_rdata == '1) ? cnt_rdata : cnt_rdata + WORD_COUNT_BITS'(1);

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    cursor_nxt    = cursor_r;
    sum_nxt       = sum_r;
    broken_nxt    = broken_r;
    ovf_nxt       = ovf_r;
    used_nxt      = used_r;
    out_valid_nxt = out_valid_r && out_stall;
    kind_nxt      = kind_r;
    last_nxt      = last_r;
    slot_nxt      = slot_r;
    end_node_nxt  = end_node_r;
    out_data_nxt  = out_data_r;
    child_we      = 1'b0;
    child_waddr   = slot_r;
    child_wdata   = used_r[NODE_W-1:0];
    cnt_we        = 1'b0;
    cnt_waddr     = end_node_r;
    cnt_wdata     = cnt_inc;

    case (state_r)
      ST_CLEAR: begin
        child_we    = 1'b1;
        child_waddr = clr_addr_r;
        child_wdata = '0;
        cnt_we      = (clr_addr_r < CNT_LIMIT);
        cnt_waddr   = clr_addr_r[NODE_W-1:0];
        cnt_wdata   = '0;
        clr_addr_nxt = clr_addr_r + SLOT_W'(1);
        if (clr_addr_r == SLOT_LAST) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_xfer) begin
          kind_nxt = in_data.kind;
          last_nxt = in_data.last;
          slot_nxt = slot_in;
          if (!broken_r) begin
            state_nxt = ST_LOOK;
          end else if (in_data.last) begin
            state_nxt = ST_EMIT;
          end
        end
      end

      ST_LOOK: begin
        state_nxt = last_r ? ST_EMIT : ST_IDLE;
        if (kind_r == KIND_INSERT) begin
          if (child_rdata == '0 && !alloc) begin
            ovf_nxt    = 1'b1;
            broken_nxt = 1'b1;
          end else begin
            cursor_nxt   = look_node;
            end_node_nxt = look_node;
            if (alloc) begin
              child_we = 1'b1;
              used_nxt = used_r + USED_W'(1);
            end
            if (last_r) begin
              state_nxt = ST_INC;
            end
          end
        end else begin
          if (child_rdata == '0) begin
            broken_nxt = 1'b1;
          end else begin
            cursor_nxt = child_rdata;
            state_nxt  = ST_ADD;
          end
        end
      end

      ST_ADD: begin
        if (sum_ext > ADD_W'(SUM_MAX)) begin
          sum_nxt = SUM_MAX;
        end else begin
          sum_nxt = sum_ext[SUM_W-1:0];
        end
        state_nxt = last_r ? ST_EMIT : ST_IDLE;
      end

      ST_INC: begin
        // Count read issued during lookup; write back saturated
        cnt_we    = 1'b1;
        state_nxt = ST_EMIT;
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.done_kind    = kind_r;
          out_data_nxt.prefix_words = (kind_r == KIND_QUERY) ? sum_r : '0;
          out_data_nxt.status       = ovf_r ? STATUS_POOL_FULL : STATUS_OK;
          cursor_nxt = '0;
          sum_nxt    = '0;
          broken_nxt = 1'b0;
          ovf_nxt    = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      cursor_r    <= '0;
      sum_r       <= '0;
      broken_r    <= 1'b0;
      ovf_r       <= 1'b0;
      used_r      <= USED_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      cursor_r    <= cursor_nxt;
      sum_r       <= sum_nxt;
      broken_r    <= broken_nxt;
      ovf_r       <= ovf_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    last_r     <= last_nxt;
    slot_r     <= slot_nxt;
    end_node_r <= end_node_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

@@ hdl/tipc_ram.sv @@
// Single-port-write, single-port-read synchronous RAM with a registered read.
// No dependencies; holds the child table and the word counts of the trie.
`timescale 1ns / 1ps

module tipc_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/tipc_checker.sv @@
// Port-level checker for the trie prefix-count block, bound to the top level.
// Depends on tipc_pkg and trie_insert_prefix_count_macros.svh.
`timescale 1ns / 1ps
`include "trie_insert_prefix_count_macros.svh"

module tipc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input tipc_pkg::tipc_out_t out_data
);

  import tipc_pkg::*;

  `TIPC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result dropped while stalled")
  `TIPC_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_data), "stalled result changed")
  `TIPC_ASSERT_NOW(a_insert_zero, clk, rst_n, out_valid && out_data.done_kind == KIND_INSERT, out_data.prefix_words == '0, "insert result carries a count")
  `TIPC_ASSERT_NEXT_ALWAYS(a_reset_quiet, clk, !rst_n, in_stall && !out_valid, "block not quiet after reset")

endmodule

bind trie_insert_prefix_count tipc_checker u_tipc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
